// File: design/tmbp_pkg.sv
// Shared types, constants and helpers for the threshold mono bitmap packer.
package tmbp_pkg;

  // Field and register widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DIM_W  = 9;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned IN_DATA_W  = 3 * PIX_W;

  // Default geometry limits
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd128;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd64;
  localparam logic [THRESH_W-1:0]  THRESH_RST = 8'd128;

  // Bit position mask within a byte
  localparam logic [BYTE_W-1:0] LSB_BIT  = 8'h01;
  localparam logic [BYTE_W-1:0] MSB_BIT  = 8'h80;
  localparam logic [2:0]        LAST_POS = 3'h7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_MODE   = 3'd2,
    REG_INVERT = 3'd3,
    REG_THRESH = 3'd4
  } cfg_reg_e;

  // Packing modes
  typedef enum logic [1:0] {
    MODE_VERT_LSB = 2'd0,
    MODE_VERT_MSB = 2'd1,
    MODE_HORZ_LSB = 2'd2,
    MODE_HORZ_MSB = 2'd3
  } pack_mode_e;

  // One-hot bit for a position, counted from LSB or MSB
  function automatic logic [BYTE_W-1:0] bit_mask(input logic [2:0] pos, input logic msb_first);
    bit_mask = msb_first ? (MSB_BIT >> pos) : (LSB_BIT << pos);
  endfunction

endpackage

// File: design/threshold_mono_bitmap_packer.sv
// Top level of the threshold mono bitmap packer: threshold, pack and output stage.
//
// Usage:
//   Slave stream takes one RGB888 pixel per word in row-major order, top row
//   first (tdata: red, green, blue from bit 0 up). Master stream gives one
//   monochrome byte per word; tlast marks the last byte of the image.
//   The user changes geometry, packing mode, invert and threshold only while idle
//   via a plain write port (cfg_we_i, cfg_addr_i, cfg_wdata_i); nothing enforces it.
// Timing:
//   One pixel per clock sustained unless output back-pressure holds a finished
//   byte. A pixel is registered with its threshold bit and counter flags, then
//   merged with its partial byte and, if the byte is complete, moved into the
//   output register. The column page store is a one-port-write, one-read
//   memory; a back-to-back write and read of the same column is forwarded.
// Reset:
//   Counters, partial row byte and handshakes clear; registers take their
//   defaults (128 x 64, vertical LSB-first, threshold 128). The page store
//   is not cleared and needs no clearing pass.
// Stall:
//   When the master side holds tready low with a word waiting, the next
//   pixel still enters the pipeline; pixels that complete no byte keep
//   flowing, and input tready drops only when a second finished byte waits.
module threshold_mono_bitmap_packer
  import tmbp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  // Packed byte stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [BYTE_W-1:0]     m_axis_tdata,   // [7:0] packed_byte
  output logic                  m_axis_tlast    // frame_end
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned CWX = (XW + 1 > CFG_DIM_W) ? XW + 1 : CFG_DIM_W;
  localparam int unsigned CWY = (YW + 1 > CFG_DIM_W) ? YW + 1 : CFG_DIM_W;

  // Configuration registers
  logic [CFG_DIM_W-1:0] width_q, height_q;
  pack_mode_e           mode_q;
  logic                 invert_q;
  logic [THRESH_W-1:0]  thresh_q;

  // Position counters and horizontal accumulator
  logic [XW-1:0]     col_q;
  logic [YW-1:0]     row_q;
  logic [BYTE_W-1:0] hacc_q;

  // Pipeline stage registers
  logic              s1_valid_q, s1_set_q, s1_first_q, s1_emit_q, s1_end_q;
  logic              s1_vert_q, s1_msb_q;
  logic [2:0]        s1_pos_q;
  logic [XW-1:0]     s1_addr_q;
  logic              fwd_hit_q;
  logic [BYTE_W-1:0] fwd_q, rd_q;

  // Output register
  logic              out_valid_q, out_end_q;
  logic [BYTE_W-1:0] out_byte_q;

  // Page store
  logic [BYTE_W-1:0] store_mem [MAX_WIDTH];

  logic              px_acc, s1_adv;
  logic [CWX-1:0]    w_ext;
  logic [CWY-1:0]    h_ext;
  logic [XW-1:0]     w_last;
  logic [YW-1:0]     h_last;
  logic              last_col, last_row, is_vert;
  logic [SUM_W-1:0]  pix_sum, limit;
  logic              pix_set;
  logic [2:0]        pos;
  logic [BYTE_W-1:0] s1_mask, s1_base, s1_acc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      mode_q   <= MODE_VERT_LSB;
      invert_q <= 1'b0;
      thresh_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        REG_MODE:   mode_q   <= pack_mode_e'(cfg_wdata_i[1:0]);
        REG_INVERT: invert_q <= cfg_wdata_i[0];
        REG_THRESH: thresh_q <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped last column and row indexes
  always_comb begin
    w_ext = CWX'(width_q);
    h_ext = CWY'(height_q);
    if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > CWX'(MAX_WIDTH)) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(w_ext - CWX'(1));
    end
    if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext > CWY'(MAX_HEIGHT)) begin
      h_last = YW'(MAX_HEIGHT - 1);
    end else begin
      h_last = YW'(h_ext - CWY'(1));
    end
  end

  assign last_col = (col_q >= w_last);
  assign last_row = (row_q >= h_last);
  assign is_vert  = (mode_q == MODE_VERT_LSB) || (mode_q == MODE_VERT_MSB);
  assign pos      = is_vert ? row_q[2:0] : col_q[2:0];

  // Threshold decision: channel sum against three times the threshold
  assign pix_sum = SUM_W'(s_axis_tdata[PIX_W-1:0]) + SUM_W'(s_axis_tdata[2*PIX_W-1:PIX_W])
                 + SUM_W'(s_axis_tdata[3*PIX_W-1:2*PIX_W]);
  assign limit   = SUM_W'({thresh_q, 1'b0}) + SUM_W'(thresh_q);
  assign pix_set = invert_q ? (pix_sum <= limit) : (pix_sum >= limit);

  // Handshake: stage 1 drains unless it holds a byte with nowhere to go
  assign s1_adv        = s1_valid_q && (!s1_emit_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign px_acc        = s_axis_tvalid && s_axis_tready;

  // Byte merge in stage 1
  assign s1_mask = bit_mask(s1_pos_q, s1_msb_q);
  always_comb begin
    if (s1_first_q) begin
      s1_base = '0;
    end else if (s1_vert_q) begin
      s1_base = fwd_hit_q ? fwd_q : rd_q;
    end else begin
      s1_base = hacc_q;
    end
    s1_acc = s1_base | (s1_set_q ? s1_mask : '0);
  end

  // Counters, stage 1 control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      hacc_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (px_acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + YW'(1);
        end else begin
          col_q <= col_q + XW'(1);
        end
        fwd_hit_q <= s1_adv && s1_vert_q && (s1_addr_q == col_q);
      end
      if (px_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv && !s1_vert_q) begin
        hacc_q <= s1_emit_q ? '0 : s1_acc;
      end
      if (s1_adv && s1_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload and output payload
  always_ff @(posedge clk_i) begin
    if (px_acc) begin
      s1_set_q   <= pix_set;
      s1_pos_q   <= pos;
      s1_first_q <= (pos == 3'd0);
      s1_emit_q  <= is_vert ? ((row_q[2:0] == LAST_POS) || last_row)
                            : ((col_q[2:0] == LAST_POS) || last_col);
      s1_end_q   <= last_col && last_row;
      s1_vert_q  <= is_vert;
      s1_msb_q   <= (mode_q == MODE_VERT_MSB) || (mode_q == MODE_HORZ_MSB);
      s1_addr_q  <= col_q;
      fwd_q      <= s1_acc;
    end
    if (s1_adv && s1_emit_q) begin
      out_byte_q <= s1_acc;
      out_end_q  <= s1_end_q;
    end
  end

  // Column page store: write from stage 1, registered read on accept
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vert_q) begin
      store_mem[s1_addr_q] <= s1_acc;
    end
    if (px_acc) begin
      rd_q <= store_mem[col_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_end_q;

  // Checks
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    px_acc && last_col && last_row |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not wrap at image end");

  a_fwd_vert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q && s1_valid_q |-> s1_vert_q)
    else $error("forwarding hit on a horizontal item");

  a_hacc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && !s1_vert_q && s1_emit_q |=> hacc_q == '0)
    else $error("row accumulator not cleared after a byte");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_emit_q))
    else $error("output word without a completed byte");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= XW'(MAX_WIDTH - 1))
    else $error("column counter out of store range");

endmodule
